FILE: sv/rsa_pkg.sv
// Shared types and constants of the running statistics accumulator.
package rsa_pkg;

    // Request codes carried by req_type.
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    // Fixed widths of the result fields.
    localparam int AVG_W = 24;
    localparam int DEV_W = 24;

    typedef logic        [23:0] cnt_out_t;
    typedef logic signed [39:0] tot_t;
    typedef logic        [54:0] tsq_t;
    typedef logic signed [15:0] ext_t;

    localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};
    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

    // The square root works on a 64-bit radicand, two bits per step.
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_TOP   = 62;

    // Results of the query engine.
    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic [DEV_W-1:0] deviation;
    } qres_t;

    // Status of the query engine.
    typedef struct packed {
        logic busy;
        logic done;
    } qstat_t;

endpackage

FILE: sv/rsa_query.sv
// Query engine: mean and standard deviation on one shared add/subtract unit.
module rsa_query
    import rsa_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int FRAC_BITS   = 8,
    localparam int SUM_W      = SAMPLE_BITS + COUNT_BITS,
    localparam int SQ_FULL    = 2 * SAMPLE_BITS + COUNT_BITS - 1,
    localparam int SQ_W       = (SQ_FULL > 64) ? 64 : SQ_FULL
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    take,
    input  logic [COUNT_BITS-1:0]   n_in,
    input  logic signed [SUM_W-1:0] sum_in,
    input  logic [SQ_W-1:0]         sumsq_in,
    output qstat_t                  stat,
    output qres_t                   res
);

    localparam int A_W    = COUNT_BITS + SQ_W;
    localparam int B_W    = 2 * SUM_W;
    localparam int AB_W   = (A_W > B_W) ? A_W : B_W;
    localparam int NN_W   = 2 * COUNT_BITS;
    localparam int D_W    = AB_W + 2 * FRAC_BITS;
    localparam int SH_W0  = (D_W > SUM_W + FRAC_BITS) ? D_W : SUM_W + FRAC_BITS;
    localparam int SH_W   = (SH_W0 > SQRT_IN_W) ? SH_W0 : SQRT_IN_W;
    localparam int ALU_W0 = (AB_W > NN_W + 1) ? AB_W : NN_W + 1;
    localparam int ALU_W  = (ALU_W0 > SQRT_IN_W + 1) ? ALU_W0 : SQRT_IN_W + 1;
    localparam int CNT_W  = $clog2(SH_W + 1);

    typedef logic [ALU_W-1:0] alu_t;
    typedef logic [ALU_W:0]   alu1_t;
    typedef logic [SH_W-1:0]  sh_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [8:0] {
        Q_IDLE = 9'b000000001,
        Q_MULN = 9'b000000010,
        Q_MULA = 9'b000000100,
        Q_MULB = 9'b000001000,
        Q_DIFF = 9'b000010000,
        Q_DIVV = 9'b000100000,
        Q_SQRT = 9'b001000000,
        Q_DIVM = 9'b010000000,
        Q_DONE = 9'b100000000
    } qstate_t;

    qstate_t          state_reg, state_next;
    alu_t             acc_reg, acc_next;
    alu_t             opnd_reg, opnd_next;
    sh_t              shf_reg, shf_next;
    cnt_t             cnt_reg, cnt_next;
    logic [NN_W-1:0]  nn_reg, nn_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [AVG_W-1:0] avg_reg, avg_next;
    logic [DEV_W-1:0] dev_reg, dev_next;

    alu_t                 alu_x;
    alu_t                 alu_y;
    logic                 alu_sub;
    alu1_t                alu_sum;
    logic                 alu_ge;
    alu_t                 rem_sh;
    alu_t                 root_try;
    alu_t                 mul_acc;
    alu_t                 d_val;
    logic [SQRT_IN_W-1:0] rad;
    logic [SUM_W-1:0]     smag;

    assign smag = sum_in[SUM_W-1] ? (~sum_in + 1'b1) : sum_in;

    // Operand selection for the shared unit.
    always_comb
    begin
        rem_sh   = {acc_reg[ALU_W-2:0], shf_reg[SH_W-1]};
        root_try = opnd_reg | alu_t'(shf_reg);
        alu_x    = acc_reg;
        alu_y    = opnd_reg;
        alu_sub  = 1'b0;
        unique case (state_reg) inside
            Q_DIVV, Q_DIVM:
            begin
                alu_x   = rem_sh;
                alu_sub = 1'b1;
            end
            Q_SQRT:
            begin
                alu_y   = root_try;
                alu_sub = 1'b1;
            end
            Q_DIFF:
            begin
                alu_x   = alu_t'(a_reg);
                alu_y   = acc_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // With subtraction, the top bit of the sum is set exactly when x < y.
    assign alu_sum = {1'b0, alu_x} + ({1'b0, alu_y} ^ {(ALU_W+1){alu_sub}})
                     + alu1_t'(alu_sub);
    assign alu_ge  = ~alu_sum[ALU_W];

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        opnd_next  = opnd_reg;
        shf_next   = shf_reg;
        cnt_next   = cnt_reg;
        nn_next    = nn_reg;
        a_next     = a_reg;
        avg_next   = avg_reg;
        dev_next   = dev_reg;

        mul_acc = shf_reg[0] ? alu_sum[ALU_W-1:0] : acc_reg;
        d_val   = alu_ge ? alu_sum[ALU_W-1:0] : '0;
        rad     = ((shf_reg >> SQRT_IN_W) != '0) ? '1 : shf_reg[SQRT_IN_W-1:0];

        unique case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    if (n_in == '0)
                    begin
                        avg_next   = '0;
                        dev_next   = '0;
                        state_next = Q_DONE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        opnd_next  = alu_t'(n_in);
                        shf_next   = sh_t'(n_in);
                        cnt_next   = cnt_t'(COUNT_BITS);
                        state_next = Q_MULN;
                    end
                end
            end
            Q_MULN:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next  = mul_acc;
                    opnd_next = opnd_reg << 1;
                    shf_next  = shf_reg >> 1;
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    nn_next    = acc_reg[NN_W-1:0];
                    acc_next   = '0;
                    opnd_next  = alu_t'(sumsq_in);
                    shf_next   = sh_t'(n_in);
                    cnt_next   = cnt_t'(COUNT_BITS);
                    state_next = Q_MULA;
                end
            end
            Q_MULA:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next  = mul_acc;
                    opnd_next = opnd_reg << 1;
                    shf_next  = shf_reg >> 1;
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    a_next     = acc_reg[A_W-1:0];
                    acc_next   = '0;
                    opnd_next  = alu_t'(smag);
                    shf_next   = sh_t'(smag);
                    cnt_next   = cnt_t'(SUM_W);
                    state_next = Q_MULB;
                end
            end
            Q_MULB:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next  = mul_acc;
                    opnd_next = opnd_reg << 1;
                    shf_next  = shf_reg >> 1;
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = Q_DIFF;
                end
            end
            Q_DIFF:
            begin
                // Scaled variance numerator n*sumsq - sum^2, clamped at zero.
                shf_next   = sh_t'(d_val) << (2 * FRAC_BITS);
                acc_next   = '0;
                opnd_next  = alu_t'(nn_reg);
                cnt_next   = cnt_t'(SH_W);
                state_next = Q_DIVV;
            end
            Q_DIVV:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = alu_ge ? alu_sum[ALU_W-1:0] : rem_sh;
                    shf_next = {shf_reg[SH_W-2:0], alu_ge};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    acc_next   = alu_t'(rad);
                    opnd_next  = '0;
                    shf_next   = sh_t'(1) << SQRT_TOP;
                    cnt_next   = cnt_t'(SQRT_STEPS);
                    state_next = Q_SQRT;
                end
            end
            Q_SQRT:
            begin
                if (cnt_reg != '0)
                begin
                    if (alu_ge)
                    begin
                        acc_next  = alu_sum[ALU_W-1:0];
                        opnd_next = (opnd_reg >> 1) | alu_t'(shf_reg);
                    end
                    else
                    begin
                        opnd_next = opnd_reg >> 1;
                    end
                    shf_next = shf_reg >> 2;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    dev_next   = (opnd_reg > alu_t'(DEV_MAX)) ? DEV_MAX
                                                              : opnd_reg[DEV_W-1:0];
                    acc_next   = '0;
                    opnd_next  = alu_t'(n_in);
                    shf_next   = sh_t'(smag) << FRAC_BITS;
                    cnt_next   = cnt_t'(SH_W);
                    state_next = Q_DIVM;
                end
            end
            Q_DIVM:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = alu_ge ? alu_sum[ALU_W-1:0] : rem_sh;
                    shf_next = {shf_reg[SH_W-2:0], alu_ge};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    // The quotient is the magnitude; apply the sign and saturate.
                    if (sum_in[SUM_W-1])
                    begin
                        avg_next = (shf_reg > sh_t'(AVG_MIN)) ? AVG_MIN
                                                              : ~shf_reg[AVG_W-1:0] + 1'b1;
                    end
                    else
                    begin
                        avg_next = (shf_reg > sh_t'(AVG_MAX)) ? AVG_MAX
                                                              : shf_reg[AVG_W-1:0];
                    end
                    state_next = Q_DONE;
                end
            end
            Q_DONE:
            begin
                if (take)
                begin
                    state_next = Q_IDLE;
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        shf_reg  <= shf_next;
        nn_reg   <= nn_next;
        a_reg    <= a_next;
        avg_reg  <= avg_next;
        dev_reg  <= dev_next;
    end

    assign stat.busy     = (state_reg != Q_IDLE);
    assign stat.done     = (state_reg == Q_DONE);
    assign res.average   = avg_reg;
    assign res.deviation = dev_reg;

endmodule

FILE: sv/running_statistics_accumulator_top.sv
// Top level of the running statistics accumulator: request intake, state and result register.
//
// Add and clear beats are taken one per cycle, back to back, while in_stall is low: each
// passes a register stage that holds the sample and its square, then updates count, sum,
// sum of squares, minimum and maximum in the following cycle. A query beat runs the query
// engine, which computes n*n, n*sumsq and sum*sum by shift-and-add, divides the clamped
// difference by n*n, takes a two-bit-per-step square root and divides the scaled sum by n,
// all on one shared add/subtract unit. While a query runs, in_stall is high. The result
// register frees the engine as soon as a result is taken or parked, so the next beat is
// accepted while a result waits on out_stall.
module running_statistics_accumulator_top
    import rsa_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [23:0]                   count,
    output logic signed [39:0]            total,
    output logic [54:0]                   total_sq,
    output logic signed [15:0]            least,
    output logic signed [15:0]            greatest,
    output logic signed [23:0]            average,
    output logic [23:0]                   deviation,
    output logic                          empty_res,
    output logic                          full_res
);

    localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_FULL = 2 * SAMPLE_BITS + COUNT_BITS - 1;
    localparam int SQ_W    = (SQ_FULL > 64) ? 64 : SQ_FULL;
    localparam int SQR_W   = 2 * SAMPLE_BITS;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic        [SQ_W-1:0]  sq_t;

    localparam logic signed [SAMPLE_BITS-1:0] MIN_RST = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MAX_RST = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Intake stage.
    logic                          pend_valid_reg, pend_valid_next;
    req_t                          pend_op_reg;
    logic signed [SAMPLE_BITS-1:0] pend_sample_reg;
    logic [SQR_W-1:0]              pend_sq_reg;

    // Accumulated state.
    logic [COUNT_BITS-1:0]          count_reg, count_next;
    sum_t                           sum_reg, sum_next;
    sq_t                            sumsq_reg, sumsq_next;
    logic signed [SAMPLE_BITS-1:0]  min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0]  max_reg, max_next;
    logic                           sat_reg, sat_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    cnt_out_t         count_o_reg;
    tot_t             total_o_reg;
    tsq_t             total_sq_o_reg;
    ext_t             least_o_reg;
    ext_t             greatest_o_reg;
    logic [AVG_W-1:0] average_o_reg;
    logic [DEV_W-1:0] deviation_o_reg;
    logic             empty_o_reg;
    logic             full_o_reg;

    logic                   accept;
    logic                   known_req;
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [SQR_W-1:0]       in_sq;
    logic                   q_start;
    logic                   slot_free;
    logic                   res_load;
    logic                   is_empty;
    qstat_t                 q_stat;
    qres_t                  q_res;

    // A query in the intake stage starts the engine next cycle; hold off until then.
    assign in_stall  = q_stat.busy || (pend_valid_reg && (pend_op_reg == REQ_QUERY));
    assign accept    = in_valid && !in_stall;
    assign known_req = (req_type == REQ_ADD) || (req_type == REQ_CLEAR)
                       || (req_type == REQ_QUERY);

    assign in_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign in_sq  = in_mag * in_mag;

    assign pend_valid_next = accept && known_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_op_reg     <= req_t'(req_type);
            pend_sample_reg <= sample;
            pend_sq_reg     <= in_sq;
        end
    end

    // Commit stage.
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        sat_next   = sat_reg;
        q_start    = 1'b0;
        if (pend_valid_reg)
        begin
            unique case (pend_op_reg)
                REQ_ADD:
                begin
                    if (count_reg == '1)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + sum_t'(pend_sample_reg);
                        sumsq_next = sumsq_reg + sq_t'(pend_sq_reg);
                        if (pend_sample_reg < min_reg)
                        begin
                            min_next = pend_sample_reg;
                        end
                        if (pend_sample_reg > max_reg)
                        begin
                            max_next = pend_sample_reg;
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                    sum_next   = '0;
                    sumsq_next = '0;
                    min_next   = MIN_RST;
                    max_next   = MAX_RST;
                    sat_next   = 1'b0;
                end
                REQ_QUERY:
                begin
                    q_start = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            min_reg   <= MIN_RST;
            max_reg   <= MAX_RST;
            sat_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            sat_reg   <= sat_next;
        end
    end

    rsa_query #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_query (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (q_start),
        .take     (slot_free),
        .n_in     (count_reg),
        .sum_in   (sum_reg),
        .sumsq_in (sumsq_reg),
        .stat     (q_stat),
        .res      (q_res)
    );

    // Result register; the state does not change while a query is in flight.
    assign slot_free = !out_valid_reg || !out_stall;
    assign res_load  = q_stat.done && slot_free;
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            count_o_reg     <= cnt_out_t'(count_reg);
            total_o_reg     <= tot_t'(sum_reg);
            total_sq_o_reg  <= tsq_t'(sumsq_reg);
            least_o_reg     <= is_empty ? ext_t'(0) : ext_t'(min_reg);
            greatest_o_reg  <= is_empty ? ext_t'(0) : ext_t'(max_reg);
            average_o_reg   <= q_res.average;
            deviation_o_reg <= q_res.deviation;
            empty_o_reg     <= is_empty;
            full_o_reg      <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_o_reg;
    assign total     = total_o_reg;
    assign total_sq  = total_sq_o_reg;
    assign least     = least_o_reg;
    assign greatest  = greatest_o_reg;
    assign average   = average_o_reg;
    assign deviation = deviation_o_reg;
    assign empty_res = empty_o_reg;
    assign full_res  = full_o_reg;

endmodule

FILE: bench/running_statistics_accumulator_top_test.sv
// Self-checking testbench of the running statistics accumulator: directed rows, then random traffic.
module running_statistics_accumulator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rsa_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int ITEMS        = 880;
    localparam int FRAC         = 8;
    localparam int MAX_WAIT     = 19;
    localparam int HOLD_CYCLES  = 2000;
    localparam int TAIL_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int MAX_LINES    = 50;

    // The one request code that the block does not decode.
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        cnt_out_t                count;
        tot_t                    total;
        tsq_t                    total_sq;
        ext_t                    least;
        ext_t                    greatest;
        logic signed [AVG_W-1:0] average;
        logic [DEV_W-1:0]        deviation;
        logic                    empty;
        logic                    full;
    } stats_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        typed;
        stats_t      want;
    } row_t;

    localparam stats_t NO_STATS    = '0;
    localparam stats_t EMPTY_STATS = {24'd0, 40'sd0, 55'd0, 16'sd0, 16'sd0, 24'sd0, 24'd0,
                                      1'b1, 1'b0};
    localparam stats_t TOP_ONLY    = {24'd1, 40'sd32767, 55'd1073676289, 16'sh7fff, 16'sh7fff,
                                      24'sd8388352, 24'd0, 1'b0, 1'b0};
    localparam stats_t BOTTOM_ONLY = {24'd1, 40'shFFFFFF8000, 55'd1073741824, 16'sh8000,
                                      16'sh8000, 24'sh800000, 24'd0, 1'b0, 1'b0};
    localparam stats_t MINUS_ONE   = {24'd1, 40'shFFFFFFFFFF, 55'd1, 16'shffff, 16'shffff,
                                      24'shFFFF00, 24'd0, 1'b0, 1'b0};

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [1:0]              req_type  = 2'd0;
    logic [15:0]             sample    = 16'd0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [23:0]             count;
    logic signed [39:0]      total;
    logic [54:0]             total_sq;
    logic signed [15:0]      least;
    logic signed [15:0]      greatest;
    logic signed [23:0]      average;
    logic [23:0]             deviation;
    logic                    empty_res;
    logic                    full_res;

    logic                    long_hold = 1'b0;
    bit                      hold_go   = 1'b0;
    bit                      calm      = 1'b0;
    int unsigned             sink_wait = 0;
    int unsigned             cycles    = 0;
    int unsigned             errors    = 0;
    int unsigned             beats_taken = 0;

    // Running state of the predictor.
    cnt_out_t tally;
    tot_t     acc_sum;
    tsq_t     acc_sq;
    ext_t     lo_seen;
    ext_t     hi_seen;
    logic     clipped;
    stats_t   stats_due[$];

    running_statistics_accumulator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count),
        .total     (total),
        .total_sq  (total_sq),
        .least     (least),
        .greatest  (greatest),
        .average   (average),
        .deviation (deviation),
        .empty_res (empty_res),
        .full_res  (full_res)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void restart_tally();
        tally   = '0;
        acc_sum = '0;
        acc_sq  = '0;
        lo_seen = 16'sh7fff;
        hi_seen = 16'sh8000;
        clipped = 1'b0;
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] trial;
        int          b;
        r = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= 128'(x))
                r = trial;
        end
        return r;
    endfunction

    function automatic stats_t stats_now();
        stats_t              s;
        logic signed [63:0]  wide_sum;
        logic [63:0]         mag;
        logic [63:0]         scaled;
        logic [63:0]         ratio;
        logic [63:0]         root;
        logic [127:0]        cross_prod;
        logic [127:0]        square;
        logic [127:0]        spread;
        logic [127:0]        quot;
        s          = NO_STATS;
        s.count    = tally;
        s.total    = acc_sum;
        s.total_sq = acc_sq;
        s.full     = clipped;
        if (tally == '0)
        begin
            s.empty = 1'b1;
            return s;
        end
        wide_sum = acc_sum;
        mag      = (wide_sum < 0) ? 64'(-wide_sum) : 64'(wide_sum);
        // The mean is truncated toward zero, so divide the magnitude and restore the sign.
        scaled   = (mag << FRAC) / 64'(tally);
        if (wide_sum < 0)
            s.average = (scaled > 64'h800000) ? 24'sh800000 : -scaled[23:0];
        else
            s.average = (scaled > 64'h7fffff) ? 24'sh7fffff : scaled[23:0];
        cross_prod = 128'(tally) * 128'(acc_sq);
        square     = 128'(mag) * 128'(mag);
        spread     = (cross_prod < square) ? 128'd0 : cross_prod - square;
        quot   = (spread << (2 * FRAC)) / (128'(tally) * 128'(tally));
        ratio  = (quot[127:64] != '0) ? '1 : quot[63:0];
        root   = floor_root(ratio);
        s.deviation = (root > 64'hffffff) ? '1 : root[23:0];
        s.least    = lo_seen;
        s.greatest = hi_seen;
        return s;
    endfunction

    function automatic void fold_request(input logic [1:0] kind, input ext_t value,
                                         input logic typed, input stats_t want);
        logic signed [16:0] wide;
        logic [16:0]        mag;
        wide = value;
        mag  = (wide < 0) ? 17'(-wide) : 17'(wide);
        case (kind)
            REQ_ADD:
            begin
                if (tally == '1)
                    clipped = 1'b1;
                else
                begin
                    tally   = tally + 1'b1;
                    acc_sum = acc_sum + value;
                    acc_sq  = acc_sq + 55'(mag) * 55'(mag);
                    if (value < lo_seen)
                        lo_seen = value;
                    if (value > hi_seen)
                        hi_seen = value;
                end
            end
            REQ_CLEAR: restart_tally();
            REQ_QUERY: stats_due.push_back(typed ? want : stats_now());
            default: ;
        endcase
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_LINES)
            $display("mismatch at cycle %0d:%s", cycles, msg);
    endtask

    task automatic check_stats(input stats_t got);
        stats_t want;
        string  diffs;
        if (stats_due.size() == 0)
        begin
            report($sformatf(" result with none outstanding, count %0d", got.count));
            return;
        end
        want  = stats_due.pop_front();
        diffs = "";
        if (got.count !== want.count)
            diffs = {diffs, $sformatf(" count %0d/%0d", got.count, want.count)};
        if (got.total !== want.total)
            diffs = {diffs, $sformatf(" total %0d/%0d", got.total, want.total)};
        if (got.total_sq !== want.total_sq)
            diffs = {diffs, $sformatf(" total_sq %0d/%0d", got.total_sq, want.total_sq)};
        if (got.least !== want.least)
            diffs = {diffs, $sformatf(" least %0d/%0d", got.least, want.least)};
        if (got.greatest !== want.greatest)
            diffs = {diffs, $sformatf(" greatest %0d/%0d", got.greatest, want.greatest)};
        if (got.average !== want.average)
            diffs = {diffs, $sformatf(" average %0d/%0d", got.average, want.average)};
        if (got.deviation !== want.deviation)
            diffs = {diffs, $sformatf(" deviation %0d/%0d", got.deviation, want.deviation)};
        if (got.empty !== want.empty)
            diffs = {diffs, $sformatf(" empty_res %0b/%0b", got.empty, want.empty)};
        if (got.full !== want.full)
            diffs = {diffs, $sformatf(" full_res %0b/%0b", got.full, want.full)};
        if (diffs != "")
            report({" got/expected", diffs});
    endtask

    // Offers one beat, waits until it is taken, then may idle for a random gap unless calm is set.
    task automatic offer(input logic [1:0] kind, input logic [15:0] value,
                         input logic typed = 1'b0, input stats_t want = '0);
        int unsigned gap;
        in_valid <= 1'b1;
        req_type <= kind;
        sample   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fold_request(kind, value, typed, want);
        if (kind != REQ_NONE)
            beats_taken++;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            req_type <= 2'($urandom);
            sample   <= 16'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge clk);
    endtask

    // A burst of samples drawn from one value profile, closed by a query.
    task automatic run_session();
        int unsigned style;
        int unsigned len;
        int unsigned k;
        logic [15:0] base;
        logic [15:0] v;
        if ($urandom_range(0, 3) == 0)
            offer(REQ_CLEAR, 16'($urandom));
        style = $urandom_range(0, 6);
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
        base  = 16'($urandom);
        for (k = 0; k < len; k++)
        begin
            case (style)
                0: v = 16'($urandom);
                1: v = base + 16'($urandom_range(0, 15)) - 16'd8;
                2: v = base;
                3: v = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
                4: v = 16'h4000 | 16'($urandom_range(0, 16'h3fff));
                5: v = 16'h8000 | 16'($urandom_range(0, 16'h3fff));
                default: v = 16'($urandom_range(0, 255)) - 16'd128;
            endcase
            if ($urandom_range(0, 19) == 0)
                offer(REQ_NONE, 16'($urandom));
            offer(REQ_ADD, v);
        end
        offer(REQ_QUERY, 16'($urandom));
        if ($urandom_range(0, 4) == 0)
            offer(REQ_QUERY, 16'($urandom));
    endtask

    // Keeps offering while the result side holds off, so that the block fills and stalls.
    task automatic flood_while_held();
        int k;
        int j;
        calm    = 1'b1;
        hold_go = 1'b1;
        for (k = 0; k < 5; k++)
        begin
            for (j = 0; j < 6; j++)
                offer(REQ_ADD, 16'($urandom));
            offer(REQ_QUERY, 16'($urandom));
        end
        calm = 1'b0;
    endtask

    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : result_sink
        if (rst_n && out_valid && !out_stall)
        begin
            check_stats({count, total, total_sq, least, greatest, average, deviation,
                         empty_res, full_res});
            sink_wait = calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
        else if (out_valid && sink_wait != 0)
            sink_wait--;
        out_stall <= long_hold || (sink_wait != 0);
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t plan[$];
        int   phase;
        restart_tally();
        plan.push_back({REQ_QUERY, 16'h0000, 1'b1, EMPTY_STATS});
        plan.push_back({REQ_ADD,   16'h7fff, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'hffff, 1'b1, TOP_ONLY});
        plan.push_back({REQ_NONE,  16'h8000, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'h0000, 1'b1, TOP_ONLY});
        plan.push_back({REQ_CLEAR, 16'h1234, 1'b0, NO_STATS});
        plan.push_back({REQ_ADD,   16'h8000, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'h5a5a, 1'b1, BOTTOM_ONLY});
        plan.push_back({REQ_ADD,   16'h7fff, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'h0000, 1'b0, NO_STATS});
        plan.push_back({REQ_CLEAR, 16'hffff, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'h0000, 1'b1, EMPTY_STATS});
        plan.push_back({REQ_ADD,   16'hffff, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'h0000, 1'b1, MINUS_ONE});
        plan.push_back({REQ_ADD,   16'h0001, 1'b0, NO_STATS});
        plan.push_back({REQ_ADD,   16'h0000, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'h0000, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'hffff, 1'b0, NO_STATS});
        plan.push_back({REQ_CLEAR, 16'h0000, 1'b0, NO_STATS});
        plan.push_back({REQ_ADD,   16'h5555, 1'b0, NO_STATS});
        plan.push_back({REQ_ADD,   16'haaaa, 1'b0, NO_STATS});
        plan.push_back({REQ_ADD,   16'h0100, 1'b0, NO_STATS});
        plan.push_back({REQ_ADD,   16'h7fff, 1'b0, NO_STATS});
        plan.push_back({REQ_ADD,   16'h8000, 1'b0, NO_STATS});
        plan.push_back({REQ_QUERY, 16'h0000, 1'b0, NO_STATS});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer(plan[i].kind, plan[i].value, plan[i].typed, plan[i].want);
        drain();

        phase = 0;
        while (beats_taken < ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (phase == 2)
                flood_while_held();
            else
                repeat ($urandom_range(6, 14)) run_session();
            drain();
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
